// File: src/isl_pkg.sv
// shared constants and codes for the indexed sequence list
package isl_pkg;

    // default sizing
    localparam int CAPACITY_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    // fixed port field widths
    localparam int OP_W     = 3;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 5;

    // request codes
    typedef enum logic [OP_W-1:0] {
        OP_INS_HEAD = 3'd0,
        OP_INS_TAIL = 3'd1,
        OP_INS_AT   = 3'd2,
        OP_RM_HEAD  = 3'd3,
        OP_RM_TAIL  = 3'd4,
        OP_RM_AT    = 3'd5,
        OP_LIST_FWD = 3'd6,
        OP_LIST_BWD = 3'd7
    } op_t;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

endpackage

// File: src/indexed_sequence_list.sv
// indexed sequence list: insert and remove at any index, one slot moved per step
// each slot move is a read in a CHK state then a write in a WR state, then the status beat
// rejected requests and empty listings go straight from idle to the status beat state
// listing: each element is read in S_LRD, then emitted in S_LOUT; output stalls hold the beat
// a new request is taken only in idle; results wait in an output register
// reset clears the element count and control; slot contents are not cleared
module indexed_sequence_list #(
    parameter int CAPACITY    = isl_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = isl_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [isl_pkg::OP_W-1:0]          operation,
    input  logic signed [isl_pkg::DATA_W-1:0] value_in,
    input  logic [isl_pkg::POS_W-1:0]         position,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [isl_pkg::DATA_W-1:0] value_out,
    output logic                              has_value,
    output logic                              last,
    output logic [isl_pkg::STATUS_W-1:0]      status,
    output logic [isl_pkg::CNT_W-1:0]         element_count,
    output logic                              is_empty
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > isl_pkg::POS_W) ? CW : isl_pkg::POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CHK,
        S_INS_WR,
        S_RM_CHK,
        S_RM_WR,
        S_LRD,
        S_LOUT,
        S_DONE
    } state_t;

    state_t                       state_reg, state_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [CW-1:0]                idx_reg, idx_next;
    logic [VALUE_WIDTH-1:0]       val_reg, val_next;
    logic                         bwd_reg, bwd_next;
    logic [isl_pkg::STATUS_W-1:0] st_reg, st_next;
    logic [CMPW-1:0]              ins_hold_reg, ins_hold_next;

    logic                         out_valid_reg, out_valid_next;
    logic [isl_pkg::DATA_W-1:0]   value_out_reg, value_out_next;
    logic                         has_value_reg, has_value_next;
    logic                         last_reg, last_next;
    logic [isl_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [isl_pkg::CNT_W-1:0]    count_out_reg, count_out_next;
    logic                         empty_reg, empty_next;

    logic                         wr_en, rd_en;
    logic [AW-1:0]                wr_addr, rd_addr;
    logic [VALUE_WIDTH-1:0]       wr_data, rd_data;
    logic [VALUE_WIDTH-1:0]       ins_data;
    logic [isl_pkg::DATA_W-1:0]   rd_wide;

    logic                         out_free;
    logic [CW-1:0]                idx_dec, idx_inc, cnt_dec, rev_idx;
    logic [CMPW-1:0]              cnt_cmp, pos_cmp, ins_pos, rm_pos;
    isl_pkg::op_t                 op_in;

    // slot storage
    isl_slot_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_WIDTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // value width adaptation on the way in and out
    generate
        if (VALUE_WIDTH < isl_pkg::DATA_W)
        begin : g_narrow
            assign ins_data = value_in[VALUE_WIDTH-1:0];
            assign rd_wide  = {{(isl_pkg::DATA_W - VALUE_WIDTH){rd_data[VALUE_WIDTH-1]}},
                               rd_data};
        end
        else
        begin : g_wide
            assign ins_data = VALUE_WIDTH'($unsigned(value_in));
            assign rd_wide  = rd_data[isl_pkg::DATA_W-1:0];
        end
    endgenerate

    // index arithmetic shared by all sequences
    assign idx_dec  = idx_reg - 1'b1;
    assign idx_inc  = idx_reg + 1'b1;
    assign cnt_dec  = count_reg - 1'b1;
    assign rev_idx  = cnt_dec - idx_reg;
    assign cnt_cmp  = CMPW'(count_reg);
    assign pos_cmp  = CMPW'(position);
    assign op_in    = isl_pkg::op_t'(operation);
    assign out_free = !out_valid_reg || !out_stall;

    // target position of an incoming request
    always_comb
    begin
        ins_pos = '0;
        rm_pos  = '0;
        unique case (op_in)
            isl_pkg::OP_INS_TAIL: ins_pos = cnt_cmp;
            isl_pkg::OP_INS_AT:   ins_pos = pos_cmp;
            isl_pkg::OP_RM_TAIL:  rm_pos  = cnt_cmp - 1'b1;
            isl_pkg::OP_RM_AT:    rm_pos  = pos_cmp;
            default:
            begin
                ins_pos = '0;
                rm_pos  = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        bwd_next       = bwd_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg;
        value_out_next = value_out_reg;
        has_value_next = has_value_reg;
        last_next      = last_reg;
        status_next    = status_reg;
        count_out_next = count_out_reg;
        empty_next     = empty_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        wr_addr        = idx_reg[AW-1:0];
        rd_addr        = idx_reg[AW-1:0];
        wr_data        = rd_data;

        // output beat taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    val_next = ins_data;
                    bwd_next = (op_in == isl_pkg::OP_LIST_BWD);
                    st_next  = isl_pkg::ST_DONE;
                    unique case (op_in) inside
                        isl_pkg::OP_INS_HEAD, isl_pkg::OP_INS_TAIL, isl_pkg::OP_INS_AT:
                        begin
                            if (ins_pos > cnt_cmp)
                            begin
                                st_next    = isl_pkg::ST_BAD;
                                state_next = S_DONE;
                            end
                            else if (count_reg == CW'(CAPACITY))
                            begin
                                st_next    = isl_pkg::ST_FULL;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                // idx walks down from the tail; insert point kept in ins_hold_reg
                                idx_next   = count_reg;
                                state_next = S_INS_CHK;
                            end
                        end
                        isl_pkg::OP_RM_HEAD, isl_pkg::OP_RM_TAIL, isl_pkg::OP_RM_AT:
                        begin
                            if (count_reg == '0 || rm_pos >= cnt_cmp)
                            begin
                                st_next    = isl_pkg::ST_BAD;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                idx_next   = CW'(rm_pos);
                                state_next = S_RM_CHK;
                            end
                        end
                        isl_pkg::OP_LIST_FWD, isl_pkg::OP_LIST_BWD:
                        begin
                            idx_next   = '0;
                            state_next = (count_reg == '0) ? S_DONE : S_LRD;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // move one slot up, or drop the new value at the insert point
            S_INS_CHK:
            begin
                if (CMPW'(idx_reg) == ins_hold_reg)
                begin
                    wr_en      = 1'b1;
                    wr_data    = val_reg;
                    count_next = count_reg + 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_dec[AW-1:0];
                    state_next = S_INS_WR;
                end
            end

            S_INS_WR:
            begin
                wr_en      = 1'b1;
                idx_next   = idx_dec;
                state_next = S_INS_CHK;
            end

            // move one slot down until the tail is reached
            S_RM_CHK:
            begin
                if (idx_inc == count_reg)
                begin
                    count_next = cnt_dec;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_inc[AW-1:0];
                    state_next = S_RM_WR;
                end
            end

            S_RM_WR:
            begin
                wr_en      = 1'b1;
                idx_next   = idx_inc;
                state_next = S_RM_CHK;
            end

            // listing: fetch one element
            S_LRD:
            begin
                rd_en      = 1'b1;
                rd_addr    = bwd_reg ? rev_idx[AW-1:0] : idx_reg[AW-1:0];
                state_next = S_LOUT;
            end

            // listing: emit one element beat
            S_LOUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    value_out_next = rd_wide;
                    has_value_next = 1'b1;
                    last_next      = (idx_inc == count_reg);
                    status_next    = isl_pkg::ST_DONE;
                    count_out_next = isl_pkg::CNT_W'(count_reg);
                    empty_next     = 1'b0;
                    idx_next       = idx_inc;
                    state_next     = (idx_inc == count_reg) ? S_IDLE : S_LRD;
                end
            end

            // single status beat
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    value_out_next = '0;
                    has_value_next = 1'b0;
                    last_next      = 1'b1;
                    status_next    = st_reg;
                    count_out_next = isl_pkg::CNT_W'(count_reg);
                    empty_next     = (count_reg == '0);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // insert point held for the whole shift sequence
    always_comb
    begin
        ins_hold_next = ins_hold_reg;
        if (state_reg == S_IDLE && in_valid)
        begin
            ins_hold_next = ins_pos;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            val_reg       <= '0;
            bwd_reg       <= 1'b0;
            st_reg        <= isl_pkg::ST_DONE;
            ins_hold_reg  <= '0;
            out_valid_reg <= 1'b0;
            value_out_reg <= '0;
            has_value_reg <= 1'b0;
            last_reg      <= 1'b0;
            status_reg    <= isl_pkg::ST_DONE;
            count_out_reg <= '0;
            empty_reg     <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            val_reg       <= val_next;
            bwd_reg       <= bwd_next;
            st_reg        <= st_next;
            ins_hold_reg  <= ins_hold_next;
            out_valid_reg <= out_valid_next;
            value_out_reg <= value_out_next;
            has_value_reg <= has_value_next;
            last_reg      <= last_next;
            status_reg    <= status_next;
            count_out_reg <= count_out_next;
            empty_reg     <= empty_next;
        end
    end

    // ports
    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign value_out     = value_out_reg;
    assign has_value     = has_value_reg;
    assign last          = last_reg;
    assign status        = status_reg;
    assign element_count = count_out_reg;
    assign is_empty      = empty_reg;

endmodule

// File: src/isl_slot_ram.sv
// slot storage: one write port, one read port with registered read data
module isl_slot_ram #(
    parameter int DEPTH = isl_pkg::CAPACITY_DEF,
    parameter int WIDTH = isl_pkg::VALUE_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
